@@ rtl/core/mret_pkg.sv @@
// package for the mouse report event tracker: widths, register indexes, helpers
`timescale 1ns / 1ps
`default_nettype none
package mret_pkg;

  localparam int unsigned BUTTONS    = 5;
  localparam int unsigned COORD_BITS = 13;

  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CLICK_W    = 3;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // squared distance and squared thresholds
  localparam int unsigned DIST_W     = 2 * COORD_BITS + 1;
  localparam int unsigned THR_SQ_W   = 2 * THR_W + 1;
  localparam int unsigned PRESS_W    = $clog2(BUTTONS + 1);
  localparam int unsigned CSUM_W     = CLICK_W + PRESS_W + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [BUTTONS-1:0]    btn_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [THR_SQ_W-1:0]   thr_sq_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_HANDED   = 3'd0,
    CFG_MOVE_THR      = 3'd1,
    CFG_DRAG_THR      = 3'd2,
    CFG_CLICK_TOL     = 3'd3,
    CFG_DCLICK_TICKS  = 3'd4,
    CFG_MAX_CLICKS    = 3'd5
  } cfg_reg_e;

  // squared euclidean distance between two points
  function automatic dist_t dist_sq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    coord_t                    dx;
    coord_t                    dy;
    logic [2*COORD_BITS-1:0]   sx;
    logic [2*COORD_BITS-1:0]   sy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    sx = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
    sy = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
    return DIST_W'(sx) + DIST_W'(sy);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/mret_in_if.sv @@
// input channel: one raw mouse report per item
`timescale 1ns / 1ps
`default_nettype none
interface mret_in_if;
  logic                               valid;
  logic                               ready;
  logic [mret_pkg::COORD_BITS-1:0]    pos_x;
  logic [mret_pkg::COORD_BITS-1:0]    pos_y;
  logic [mret_pkg::BUTTONS-1:0]       buttons;
  logic [mret_pkg::STAMP_W-1:0]       stamp;

  modport source (output valid, output pos_x, output pos_y, output buttons,
                  output stamp, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input buttons,
                  input stamp, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mret_out_if.sv @@
// output channel: event flags and click state per report
`timescale 1ns / 1ps
`default_nettype none
interface mret_out_if;
  logic                             valid;
  logic                             ready;
  logic                             moved;
  logic                             left_down;
  logic                             left_up;
  logic [mret_pkg::CLICK_W-1:0]     click_count;
  logic                             dragging;
  logic [mret_pkg::EVENT_W-1:0]     event_count;

  modport source (output valid, output moved, output left_down, output left_up,
                  output click_count, output dragging, output event_count,
                  input ready);
  modport sink   (input valid, input moved, input left_down, input left_up,
                  input click_count, input dragging, input event_count,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/mouse_report_event_tracker_top.sv @@
// mouse report event tracker: move, button edge, multi-click and drag detection
`timescale 1ns / 1ps
`default_nettype none
// Each item on in_i is one raw mouse report (position, physical button mask,
// timestamp); each produces exactly one item on out_o with the move flag,
// logical left down/up flags, the multi-click count, the drag state and the
// number of events posted. The block has an input register and a result
// register with combinational logic between them, and a new report is taken
// every cycle while out_o is not stalled; the tracker state (last position,
// previous mask, click and press points) is updated in the same cycle the
// result is registered, which is what lets reports follow back to back.
// Distances are compared squared against squared thresholds, which are
// worked out when a threshold register is written, so the per-report path
// is one 13x13 square per axis, an add and a compare. The user must write
// configuration registers through cfg_we_i / cfg_idx_i / cfg_data_i only
// while no report is in flight; the block itself does not enforce this.
// Unknown indexes are ignored.
module mouse_report_event_tracker_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [mret_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [mret_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  mret_in_if.sink                            in_i,
  mret_out_if.source                         out_o
);
  import mret_pkg::*;

  // configuration, with squared thresholds kept alongside
  logic                 left_handed_q;
  thr_sq_t              move_sq_q,  move_sq_d;
  thr_sq_t              drag_sq_q,  drag_sq_d;
  thr_sq_t              tol1_sq_q,  tol1_sq_d;
  logic [STAMP_W-1:0]   dclick_ticks_q;
  logic [CLICK_W-1:0]   max_clicks_q;
  logic [THR_W-1:0]     cfg_thr;
  logic [THR_W:0]       cfg_thr1;

  // input register
  logic                 s1_valid_q;
  coord_t               s1_x_q, s1_y_q;
  btn_t                 s1_btn_q;
  logic [STAMP_W-1:0]   s1_stamp_q;

  // tracker state
  coord_t               cur_x_q, cur_y_q;
  btn_t                 prev_btn_q;
  coord_t               click_x_q, click_y_q;
  logic [STAMP_W-1:0]   click_time_q;
  logic [CLICK_W-1:0]   clicks_q, clicks_d;
  coord_t               press_x_q, press_y_q;
  logic                 drag_q, drag_d;

  // result register
  logic                 out_valid_q;
  logic                 moved_q, moved_d;
  logic                 down_q, down_d;
  logic                 up_q, up_d;
  logic [EVENT_W-1:0]   events_q, events_d;

  logic                 advance;
  btn_t                 changes, presses, releases;
  logic                 left_sel;
  logic [PRESS_W-1:0]   n_press;
  logic                 gate;
  logic [CSUM_W-1:0]    csum;
  logic [CSUM_W-1:0]    cmax;
  coord_t               px, py;
  dist_t                move_d2, click_d2, drag_d2;
  logic [STAMP_W-1:0]   dt;

  // handshake: the result register drains while the input register refills
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  // squared thresholds from the write data
  assign cfg_thr  = cfg_data_i[THR_W-1:0];
  assign cfg_thr1 = {1'b0, cfg_thr} + (THR_W+1)'(1);

  always_comb begin
    move_sq_d = move_sq_q;
    drag_sq_d = drag_sq_q;
    tol1_sq_d = tol1_sq_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MOVE_THR:  move_sq_d = THR_SQ_W'(cfg_thr) * THR_SQ_W'(cfg_thr);
        CFG_DRAG_THR:  drag_sq_d = THR_SQ_W'(cfg_thr) * THR_SQ_W'(cfg_thr);
        CFG_CLICK_TOL: tol1_sq_d = THR_SQ_W'(cfg_thr1) * THR_SQ_W'(cfg_thr1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_handed_q  <= 1'b0;
      move_sq_q      <= THR_SQ_W'(1);
      drag_sq_q      <= THR_SQ_W'(16);
      tol1_sq_q      <= THR_SQ_W'(25);
      dclick_ticks_q <= STAMP_W'(30);
      max_clicks_q   <= CLICK_W'(3);
    end else begin
      move_sq_q <= move_sq_d;
      drag_sq_q <= drag_sq_d;
      tol1_sq_q <= tol1_sq_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LEFT_HANDED:  left_handed_q  <= cfg_data_i[0];
          CFG_DCLICK_TICKS: dclick_ticks_q <= cfg_data_i[STAMP_W-1:0];
          CFG_MAX_CLICKS:   max_clicks_q   <= cfg_data_i[CLICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_x_q     <= in_i.pos_x;
      s1_y_q     <= in_i.pos_y;
      s1_btn_q   <= in_i.buttons;
      s1_stamp_q <= in_i.stamp;
    end
  end

  // report processing
  always_comb begin
    // move test against the last position
    move_d2 = dist_sq(cur_x_q, cur_y_q, s1_x_q, s1_y_q);
    moved_d = ((s1_x_q != cur_x_q) || (s1_y_q != cur_y_q)) &&
              (move_d2 >= DIST_W'(move_sq_q));

    // button edges against the previous report
    changes  = s1_btn_q ^ prev_btn_q;
    presses  = changes & s1_btn_q;
    releases = changes & ~s1_btn_q;
    left_sel = left_handed_q;
    down_d   = left_sel ? presses[1]  : presses[0];
    up_d     = left_sel ? releases[1] : releases[0];
    n_press  = PRESS_W'($countones(presses));

    // multi-click: first press is gated, every further press in the same
    // report always passes the gate
    dt       = s1_stamp_q - click_time_q;
    click_d2 = dist_sq(s1_x_q, s1_y_q, click_x_q, click_y_q);
    gate     = (dt <= dclick_ticks_q) && (click_d2 < DIST_W'(tol1_sq_q));
    csum     = (gate ? CSUM_W'(clicks_q) : CSUM_W'(0)) + CSUM_W'(n_press);
    cmax     = CSUM_W'(max_clicks_q);
    if (n_press == '0) begin
      clicks_d = clicks_q;
    end else if (!gate && (n_press == PRESS_W'(1))) begin
      clicks_d = CLICK_W'(1);
    end else if (csum > cmax) begin
      clicks_d = max_clicks_q;
    end else begin
      clicks_d = csum[CLICK_W-1:0];
    end

    // press point follows a logical left press in this report
    px = down_d ? s1_x_q : press_x_q;
    py = down_d ? s1_y_q : press_y_q;

    // any release ends a drag; physical button one held far enough starts one
    drag_d2 = dist_sq(px, py, s1_x_q, s1_y_q);
    drag_d  = drag_q && !(|releases);
    if (s1_btn_q[0] && !drag_d) begin
      drag_d = (drag_d2 >= DIST_W'(drag_sq_q));
    end

    events_d = EVENT_W'(moved_d) + EVENT_W'(down_d) + EVENT_W'(up_d);
  end

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      prev_btn_q   <= '0;
      click_x_q    <= '0;
      click_y_q    <= '0;
      click_time_q <= '0;
      clicks_q     <= '0;
      press_x_q    <= '0;
      press_y_q    <= '0;
      drag_q       <= 1'b0;
    end else if (advance) begin
      cur_x_q    <= s1_x_q;
      cur_y_q    <= s1_y_q;
      prev_btn_q <= s1_btn_q;
      clicks_q   <= clicks_d;
      press_x_q  <= px;
      press_y_q  <= py;
      drag_q     <= drag_d;
      if (|presses) begin
        click_x_q    <= s1_x_q;
        click_y_q    <= s1_y_q;
        click_time_q <= s1_stamp_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      moved_q  <= moved_d;
      down_q   <= down_d;
      up_q     <= up_d;
      events_q <= events_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.moved       = moved_q;
  assign out_o.left_down   = down_q;
  assign out_o.left_up     = up_q;
  assign out_o.click_count = clicks_q;
  assign out_o.dragging    = drag_q;
  assign out_o.event_count = events_q;

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// self-checking testbench for the mouse report event tracker
`timescale 1ns / 1ps
module tb_top;
  import mret_pkg::*;

  localparam int IDLE_PCT    = 11;       // chance in a hundred that a side idles
  localparam int CYCLE_LIMIT = 200000;   // hard stop, far beyond the slowest good run
  localparam int STALL_AT    = 300;      // accepted items before the long sink stall
  localparam int STALL_LEN   = 80;
  localparam int CALM_FROM   = 500;      // window of accepted items with no idling
  localparam int CALM_TO     = 650;
  localparam int PHASE_ITEMS = 150;

  // index past the register list, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct packed {
    coord_t      x;
    coord_t      y;
    btn_t        mask;
    logic [31:0] stamp;
  } report_t;

  typedef struct packed {
    logic               moved;
    logic               down;
    logic               up;
    logic [CLICK_W-1:0] clicks;
    logic               drag;
    logic [EVENT_W-1:0] events;
  } events_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mret_in_if  in_if ();
  mret_out_if out_if ();

  mouse_report_event_tracker_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // reports waiting to be offered, and event results still owed by the block
  report_t pending_reports[$];
  events_t due_events[$];

  int reports_queued = 0;
  int reports_in     = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  logic in_taken     = 1'b0;
  report_t next_report;

  // tracker copy: configuration, reset values
  logic              cfg_swap   = 1'b0;
  logic [7:0]        thr_move   = 8'd1;
  logic [7:0]        thr_drag   = 8'd4;
  logic [7:0]        tol_click  = 8'd4;
  logic [31:0]       gap_ticks  = 32'd30;
  logic [CLICK_W-1:0] click_cap = 3'd3;

  // tracker copy: state, all cleared by reset
  coord_t             prior_x   = '0;
  coord_t             prior_y   = '0;
  btn_t               held_mask = '0;
  coord_t             tap_x     = '0;
  coord_t             tap_y     = '0;
  logic [31:0]        tap_stamp = '0;
  logic [CLICK_W-1:0] tap_count = '0;
  coord_t             anchor_x  = '0;
  coord_t             anchor_y  = '0;
  logic               drag_on   = 1'b0;

  // gesture generator state
  coord_t      g_x       = '0;
  coord_t      g_y       = '0;
  btn_t        g_mask    = '0;
  logic [31:0] g_stamp   = '0;
  btn_t        burst_bit = '0;
  int          burst_left = 0;

  // stall bookkeeping for the sink
  int stall_left = 0;
  bit stall_done = 1'b0;

  function automatic longint unsigned sq_dist(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint unsigned dx;
    longint unsigned dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return dx * dx + dy * dy;
  endfunction

  // truncated distance at least t
  function automatic bit is_far(longint unsigned d2, logic [7:0] t);
    longint unsigned tt;
    tt = t;
    return d2 >= tt * tt;
  endfunction

  // truncated distance at most t
  function automatic bit is_near(longint unsigned d2, logic [7:0] t);
    longint unsigned tt;
    tt = t;
    tt = tt + 1;
    return d2 < tt * tt;
  endfunction

  // advance the tracker copy by one report and give the events it posts
  function automatic events_t track_report(report_t r);
    events_t     ev;
    btn_t        flips;
    int          left_idx;
    int          i;
    logic [31:0] elapsed;
    logic [3:0]  bump;
    ev = '0;
    if (r.x != prior_x || r.y != prior_y) begin
      if (is_far(sq_dist(prior_x, prior_y, r.x, r.y), thr_move)) ev.moved = 1'b1;
    end
    prior_x = r.x;
    prior_y = r.y;

    left_idx = cfg_swap ? 1 : 0;
    flips = r.mask ^ held_mask;
    // buttons walked from bit 0 upwards, every press runs the click update
    for (i = 0; i < BUTTONS; i++) begin
      if (flips[i]) begin
        if (r.mask[i]) begin
          elapsed = r.stamp - tap_stamp;
          if (elapsed <= gap_ticks && is_near(sq_dist(r.x, r.y, tap_x, tap_y), tol_click)) begin
            bump = {1'b0, tap_count} + 4'd1;
            tap_count = (bump > {1'b0, click_cap}) ? click_cap : bump[CLICK_W-1:0];
          end else begin
            tap_count = 3'd1;
          end
          tap_x = r.x;
          tap_y = r.y;
          tap_stamp = r.stamp;
          if (i == left_idx) begin
            ev.down = 1'b1;
            anchor_x = r.x;
            anchor_y = r.y;
          end
        end else begin
          if (i == left_idx) ev.up = 1'b1;
          drag_on = 1'b0;
        end
      end
    end
    held_mask = r.mask;

    // drag looks at physical button one whatever the handedness
    if (r.mask[0] && !drag_on) begin
      if (is_far(sq_dist(anchor_x, anchor_y, r.x, r.y), thr_drag)) drag_on = 1'b1;
    end

    ev.clicks = tap_count;
    ev.drag   = drag_on;
    ev.events = 2'(ev.moved) + 2'(ev.down) + 2'(ev.up);
    return ev;
  endfunction

  function automatic bit calm_window();
    return reports_in >= CALM_FROM && reports_in < CALM_TO;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers the next pending report, idling now and then
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (pending_reports.size() != 0 && (calm_window() || $urandom_range(99) >= IDLE_PCT)) begin
        next_report = pending_reports.pop_front();
        in_if.valid   <= 1'b1;
        in_if.pos_x   <= next_report.x;
        in_if.pos_y   <= next_report.y;
        in_if.buttons <= next_report.mask;
        in_if.stamp   <= next_report.stamp;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (!stall_done && reports_in >= STALL_AT) begin
        stall_done = 1'b1;
        stall_left = STALL_LEN;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm_window() || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted report, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    events_t got;
    events_t want;
    in_taken <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        due_events.push_back(track_report('{x: in_if.pos_x, y: in_if.pos_y,
                                            mask: in_if.buttons, stamp: in_if.stamp}));
        reports_in++;
      end
      if (out_if.valid && out_if.ready) begin
        got.moved  = out_if.moved;
        got.down   = out_if.left_down;
        got.up     = out_if.left_up;
        got.clicks = out_if.click_count;
        got.drag   = out_if.dragging;
        got.events = out_if.event_count;
        if (due_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing owed: moved=%0d down=%0d up=%0d "
                     , results_seen, got.moved, got.down, got.up,
                     "clicks=%0d drag=%0d events=%0d", got.clicks, got.drag, got.events);
        end else begin
          want = due_events.pop_front();
          if (got.moved !== want.moved || got.down !== want.down || got.up !== want.up ||
              got.clicks !== want.clicks || got.drag !== want.drag ||
              got.events !== want.events) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected moved=%0d down=%0d up=%0d clicks=%0d ",
                       results_seen, want.moved, want.down, want.up, want.clicks,
                       "drag=%0d events=%0d, got moved=%0d down=%0d up=%0d clicks=%0d ",
                       want.drag, want.events, got.moved, got.down, got.up, got.clicks,
                       "drag=%0d events=%0d", got.drag, got.events);
          end
        end
        results_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic add_report(coord_t x, coord_t y, btn_t mask, logic [31:0] stamp);
    pending_reports.push_back('{x: x, y: y, mask: mask, stamp: stamp});
    reports_queued++;
  endtask

  // register write, mirrored into the tracker copy with the register widths
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LEFT_HANDED:  cfg_swap  = data[0];
      CFG_MOVE_THR:     thr_move  = data[7:0];
      CFG_DRAG_THR:     thr_drag  = data[7:0];
      CFG_CLICK_TOL:    tol_click = data[7:0];
      CFG_DCLICK_TICKS: gap_ticks = data;
      CFG_MAX_CLICKS:   click_cap = data[CLICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] swap, logic [31:0] mv, logic [31:0] dg,
                         logic [31:0] tol, logic [31:0] ticks, logic [31:0] cap);
    write_reg(CFG_LEFT_HANDED, swap);
    write_reg(CFG_MOVE_THR, mv);
    write_reg(CFG_DRAG_THR, dg);
    write_reg(CFG_CLICK_TOL, tol);
    write_reg(CFG_DCLICK_TICKS, ticks);
    write_reg(CFG_MAX_CLICKS, cap);
  endtask

  // hold until every queued item is in and every owed result is out
  task automatic settle();
    @(negedge clk);
    while (pending_reports.size() != 0 || reports_in != reports_queued ||
           due_events.size() != 0)
      @(negedge clk);
  endtask

  // pointer walks, clicks, multi-click bursts and drags, with some pure noise
  task automatic queue_gestures(int count);
    int n;
    int k;
    int m;
    for (n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (burst_left != 0) begin
        // stationary press/release train
        g_mask  = g_mask ^ burst_bit;
        g_stamp = g_stamp + $urandom_range(1, 6);
        burst_left--;
      end else if (k < 10) begin
        g_x     = coord_t'($urandom);
        g_y     = coord_t'($urandom);
        g_mask  = btn_t'($urandom);
        g_stamp = $urandom;
      end else if (k < 16) begin
        burst_left = 2 * $urandom_range(1, 7);
        burst_bit  = ($urandom_range(99) < 70) ? btn_t'(1)
                                               : btn_t'(1) << $urandom_range(BUTTONS - 1);
        g_mask  = g_mask ^ burst_bit;
        g_stamp = g_stamp + $urandom_range(1, 6);
      end else begin
        m = $urandom_range(99);
        if (m < 5) begin
          g_x = g_x + coord_t'($urandom_range(600) - 300);
          g_y = g_y + coord_t'($urandom_range(600) - 300);
        end else if (m >= 35) begin
          g_x = g_x + coord_t'($urandom_range(12) - 6);
          g_y = g_y + coord_t'($urandom_range(12) - 6);
        end
        if ($urandom_range(99) < 8) g_stamp = g_stamp + $urandom;
        else g_stamp = g_stamp + $urandom_range(25);
        m = $urandom_range(99);
        if (m < 45) ;
        else if (m < 75) g_mask[0] = !g_mask[0];
        else if (m < 85) g_mask[1] = !g_mask[1];
        else if (m < 93) g_mask = g_mask ^ (btn_t'(1) << $urandom_range(BUTTONS - 1));
        else g_mask = btn_t'($urandom);
      end
      add_report(g_x, g_y, g_mask, g_stamp);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    in_if.valid   = 1'b0;
    in_if.pos_x   = '0;
    in_if.pos_y   = '0;
    in_if.buttons = '0;
    in_if.stamp   = '0;
    out_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_LEFT_HANDED;
    cfg_data      = '0;
    rst_n         = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset settings, hand-picked reports
    add_report(13'd0, 13'd0, 5'b00000, 32'd0);       // first report on the reset position
    add_report(13'd1, 13'd0, 5'b00001, 32'd5);       // one pixel move and left press
    add_report(13'd1, 13'd0, 5'b00000, 32'd10);      // left release
    add_report(13'd1, 13'd0, 5'b00001, 32'd20);      // double click
    add_report(13'd1, 13'd0, 5'b00000, 32'd22);
    add_report(13'd2, 13'd1, 5'b00001, 32'd30);      // triple click
    add_report(13'd2, 13'd1, 5'b00000, 32'd32);
    add_report(13'd2, 13'd1, 5'b00001, 32'd34);      // count saturates
    add_report(13'd6, 13'd1, 5'b00001, 32'd36);      // drag starts at the threshold
    add_report(13'd6, 13'd1, 5'b00101, 32'd38);      // extra press while dragging
    add_report(13'd6, 13'd1, 5'b00001, 32'd40);      // other release ends drag, far so restarts
    add_report(13'd2, 13'd1, 5'b00101, 32'd42);
    add_report(13'd2, 13'd1, 5'b00001, 32'd43);      // release ends drag on the press point
    add_report(13'd2, 13'd1, 5'b11110, 32'd44);      // left up plus four presses at once
    add_report(13'd2, 13'd1, 5'b00000, 32'd45);
    add_report(13'h1FFF, 13'h1FFF, 5'b00000, 32'd46);
    add_report(13'd0, 13'd0, 5'b11111, 32'hFFFF_FFFF);
    add_report(13'd0, 13'd0, 5'b00000, 32'hFFFF_FFF0);
    add_report(13'd0, 13'd0, 5'b00001, 32'h0000_0005); // time difference wraps round
    add_report(13'd0, 13'd0, 5'b00000, 32'd6);
    add_report(13'd0, 13'd0, 5'b00001, 32'd100);     // too late for a multi-click
    add_report(13'd0, 13'd0, 5'b00000, 32'd101);
    add_report(13'd5, 13'd0, 5'b00001, 32'd102);     // too far for a multi-click
    add_report(13'd5, 13'd0, 5'b00000, 32'd103);
    settle();

    // low extremes, left-handed, stray index write
    set_all(32'h0000_0003, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    write_reg(CFG_IDX_SPARE, $urandom);
    add_report(13'd10, 13'd10, 5'b00010, 32'd200);   // logical left is button two
    add_report(13'd10, 13'd10, 5'b00000, 32'd200);
    add_report(13'd10, 13'd10, 5'b00001, 32'd200);   // button one still drives the drag
    add_report(13'd10, 13'd10, 5'b00000, 32'd201);
    queue_gestures(PHASE_ITEMS);
    settle();

    // high extremes, upper data bits must be dropped
    set_all(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_01FF, 32'd255, 32'hFFFF_FFFF, 32'd7);
    queue_gestures(PHASE_ITEMS);
    settle();

    // lower click limit, a high count gets clamped on the next gated press
    set_all(32'd0, 32'd2, 32'd3, 32'd6, 32'd40, 32'd2);
    queue_gestures(PHASE_ITEMS);
    settle();

    // zero click limit, written as 8 to check the width
    set_all(32'd1, 32'd1, 32'd5, 32'd10, 32'd100, 32'd8);
    queue_gestures(PHASE_ITEMS);
    settle();

    for (p = 0; p < 3; p++) begin
      set_all($urandom_range(1), $urandom_range(12), $urandom_range(12), $urandom_range(12),
              $urandom_range(80), $urandom_range(7));
      queue_gestures(PHASE_ITEMS);
      settle();
    end

    // allow for anything stray still coming out of the pipe
    repeat (8) @(negedge clk);
    if (mismatches == 0 && due_events.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
